### rtl/fwsx_pkg.sv
package fwsx_pkg;

	localparam int NUM_CH          = 5;
	localparam int CTRL_W          = 16;
	localparam int GAIN_W          = 16;
	localparam int SAMPLE_BITS_DEF = 16;

	// ramp numerators are scaled by 300; they fit 24 bits once known non-negative
	localparam int RAMP_W          = 24;
	localparam int CALC_W          = 28;

	// Q1.15 positions
	localparam int Q_ONE   = 32768;
	localparam int POS_7_8 = 28672;
	localparam int POS_5_8 = 20480;
	localparam int POS_1_2 = 16384;
	localparam int POS_3_8 = 12288;
	localparam int POS_1_8 = 4096;
	localparam int G1_MAX  = 26214;

	// ramp slope 8/3 as 800/300, offsets 1.33 and 2.675 scaled by 32768*300
	localparam int SLOPE   = 800;
	localparam int ROUND   = 150;
	localparam int OFS_133  = 13074432;
	localparam int OFS_2675 = 26296320;

	// floor(n/300) == (n * RECIP) >> RECIP_SHIFT for every n below 2**RAMP_W
	localparam int RECIP       = 14316558;
	localparam int RECIP_W     = 24;
	localparam int RECIP_SHIFT = 32;

	typedef enum logic [1:0] {
		GM_ZERO,
		GM_ONE,
		GM_RAMP,
		GM_FIXED
	} gain_mode_t;

	// per-stage load enables from the pipeline control
	typedef struct packed {
		logic s1;
		logic s2;
		logic s3;
		logic s4;
		logic s5;
	} stage_ld_t;

endpackage

### rtl/fwsx_in_if.sv
interface fwsx_in_if #(
	parameter int SAMPLE_BITS = fwsx_pkg::SAMPLE_BITS_DEF
);
	logic                          valid;
	logic                          ready;
	logic signed [15:0]            control;
	logic signed [SAMPLE_BITS-1:0] sample_1;
	logic signed [SAMPLE_BITS-1:0] sample_2;
	logic signed [SAMPLE_BITS-1:0] sample_3;
	logic signed [SAMPLE_BITS-1:0] sample_4;
	logic signed [SAMPLE_BITS-1:0] sample_5;

	modport source (
		output valid, control, sample_1, sample_2, sample_3, sample_4, sample_5,
		input  ready
	);

	modport sink (
		input  valid, control, sample_1, sample_2, sample_3, sample_4, sample_5,
		output ready
	);
endinterface

### rtl/fwsx_out_if.sv
interface fwsx_out_if #(
	parameter int SAMPLE_BITS = fwsx_pkg::SAMPLE_BITS_DEF
);
	logic                          valid;
	logic                          ready;
	logic signed [SAMPLE_BITS+2:0] mix;

	modport source (
		output valid, mix,
		input  ready
	);

	modport sink (
		input  valid, mix,
		output ready
	);
endinterface

### rtl/fwsx_gain.sv
module fwsx_gain (
	input  logic                                           clk,
	input  fwsx_pkg::stage_ld_t                            ld,
	input  logic signed [fwsx_pkg::CTRL_W-1:0]             control,
	output logic [fwsx_pkg::NUM_CH-1:0][fwsx_pkg::GAIN_W-1:0] gain_s3
);
	import fwsx_pkg::*;

	localparam int PROD_W = RAMP_W + RECIP_W;

	localparam logic signed [CALC_W-1:0] K_SLOPE = CALC_W'(SLOPE);
	localparam logic signed [CALC_W-1:0] K_ROUND = CALC_W'(ROUND);
	localparam logic signed [CALC_W-1:0] K_ONE   = CALC_W'(Q_ONE);
	localparam logic signed [CALC_W-1:0] K_G1MAX = CALC_W'(G1_MAX);
	localparam logic signed [CALC_W-1:0] K_78    = CALC_W'(POS_7_8);
	localparam logic signed [CALC_W-1:0] K_38    = CALC_W'(POS_3_8);
	localparam logic signed [CALC_W-1:0] K_18    = CALC_W'(POS_1_8);
	localparam logic signed [CALC_W-1:0] K_12    = CALC_W'(POS_1_2);
	localparam logic signed [CALC_W-1:0] K_O133  = CALC_W'(OFS_133);
	localparam logic signed [CALC_W-1:0] K_O2675 = CALC_W'(OFS_2675);

	localparam logic signed [CTRL_W-1:0] X_78 = CTRL_W'(POS_7_8);
	localparam logic signed [CTRL_W-1:0] X_58 = CTRL_W'(POS_5_8);
	localparam logic signed [CTRL_W-1:0] X_12 = CTRL_W'(POS_1_2);
	localparam logic signed [CTRL_W-1:0] X_38 = CTRL_W'(POS_3_8);
	localparam logic signed [CTRL_W-1:0] X_18 = CTRL_W'(POS_1_8);

	localparam logic [RECIP_W-1:0] K_RECIP = RECIP_W'(RECIP);
	localparam logic [GAIN_W:0]    Q_MAX   = (GAIN_W+1)'(Q_ONE);

	logic signed [CALC_W-1:0] xw;
	logic signed [CALC_W-1:0] g1_t;
	logic signed [CALC_W-1:0] n2, n3, n4, n5;
	gain_mode_t [NUM_CH-1:0]  mode_d;
	logic [NUM_CH-1:0][RAMP_W-1:0] n_d;

	gain_mode_t [NUM_CH-1:0]  mode_s1, mode_s2;
	logic [NUM_CH-1:0][RAMP_W-1:0] n_s1;
	logic [NUM_CH-1:0][PROD_W-1:0] prod_s2;
	logic [NUM_CH-1:0][GAIN_W-1:0] fix_s2;

	// stage 1: pick the segment of each trapezoid, scaled numerator for ramps
	always_comb begin
		xw = {{(CALC_W-CTRL_W){control[CTRL_W-1]}}, control};

		g1_t = -(xw <<< 1) - K_ONE;
		mode_d[0] = GM_FIXED;
		if (g1_t < 0) begin
			n_d[0] = '0;
		end else if (g1_t > K_G1MAX) begin
			n_d[0] = K_G1MAX[RAMP_W-1:0];
		end else begin
			n_d[0] = g1_t[RAMP_W-1:0];
		end

		// channel two
		if (control >= X_38 * -1) begin
			n2 = -(K_SLOPE * xw) + K_ROUND;
		end else begin
			n2 = K_SLOPE * (xw + K_78) + K_ROUND;
		end
		if (control < -X_78 || control >= 0) begin
			mode_d[1] = GM_ZERO;
		end else if (control > -X_12 && control < -X_38) begin
			mode_d[1] = GM_ONE;
		end else begin
			mode_d[1] = GM_RAMP;
		end
		n_d[1] = n2[RAMP_W-1:0];

		// channel three; its falling ramp dips below zero near one half
		if (control >= X_18) begin
			n3 = -(K_SLOPE * xw) + K_O133 + K_ROUND;
		end else begin
			n3 = K_SLOPE * (xw + K_38) + K_ROUND;
		end
		if (control < -X_38 || control >= X_12 || n3 < 0) begin
			mode_d[2] = GM_ZERO;
		end else if (control > 0 && control < X_18) begin
			mode_d[2] = GM_ONE;
		end else begin
			mode_d[2] = GM_RAMP;
		end
		n_d[2] = n3[RAMP_W-1:0];

		// channel four
		if (control >= X_58) begin
			n4 = -(K_SLOPE * xw) + K_O2675 + K_ROUND;
		end else begin
			n4 = K_SLOPE * (xw - K_18) + K_ROUND;
		end
		if (control < X_18 || n4 < 0) begin
			mode_d[3] = GM_ZERO;
		end else if (control > X_12 && control < X_58) begin
			mode_d[3] = GM_ONE;
		end else begin
			mode_d[3] = GM_RAMP;
		end
		n_d[3] = n4[RAMP_W-1:0];

		// channel five: one rising ramp, clamped later
		n5 = K_SLOPE * (xw - K_12) + K_ROUND;
		mode_d[4] = (n5 < 0) ? GM_ZERO : GM_RAMP;
		n_d[4] = n5[RAMP_W-1:0];
	end

	always_ff @(posedge clk) begin
		if (ld.s1) begin
			mode_s1 <= mode_d;
			n_s1    <= n_d;
		end
	end

	// stage 2: divide by 300 through the reciprocal product
	always_ff @(posedge clk) begin
		if (ld.s2) begin
			mode_s2 <= mode_s1;
			for (int i = 0; i < NUM_CH; i++) begin
				prod_s2[i] <= PROD_W'(n_s1[i]) * PROD_W'(K_RECIP);
				fix_s2[i]  <= n_s1[i][GAIN_W-1:0];
			end
		end
	end

	// stage 3: clamp to 1.0 and apply the segment
	logic [NUM_CH-1:0][GAIN_W:0]   q_d;
	logic [NUM_CH-1:0][GAIN_W-1:0] gain_d;

	always_comb begin
		for (int i = 0; i < NUM_CH; i++) begin
			// the quotient stays below 2**GAIN_W for every ramp numerator
			q_d[i] = {1'b0, prod_s2[i][RECIP_SHIFT +: GAIN_W]};
			unique case (mode_s2[i])
				GM_ZERO:  gain_d[i] = '0;
				GM_ONE:   gain_d[i] = Q_MAX[GAIN_W-1:0];
				GM_FIXED: gain_d[i] = fix_s2[i];
				GM_RAMP: begin
					gain_d[i] = (q_d[i] > Q_MAX) ? Q_MAX[GAIN_W-1:0] : q_d[i][GAIN_W-1:0];
				end
				default:  gain_d[i] = '0;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (ld.s3) begin
			gain_s3 <= gain_d;
		end
	end

endmodule

### rtl/fwsx_mac.sv
module fwsx_mac #(
	parameter int SAMPLE_BITS = fwsx_pkg::SAMPLE_BITS_DEF
) (
	input  logic                                               clk,
	input  fwsx_pkg::stage_ld_t                                ld,
	input  logic [fwsx_pkg::NUM_CH-1:0][SAMPLE_BITS-1:0]       sample,
	input  logic [fwsx_pkg::NUM_CH-1:0][fwsx_pkg::GAIN_W-1:0]  gain_s3,
	output logic signed [SAMPLE_BITS+2:0]                      mix_s5
);
	import fwsx_pkg::*;

	localparam int PW = SAMPLE_BITS + GAIN_W + 1;
	localparam int SW = PW + 3;

	logic [NUM_CH-1:0][SAMPLE_BITS-1:0] smp_s1, smp_s2, smp_s3;
	logic [NUM_CH-1:0][PW-1:0]          prod_s4;
	logic [NUM_CH-1:0][PW-1:0]          prod_d;
	logic signed [PW-1:0]               a_ext [NUM_CH];
	logic signed [PW-1:0]               b_ext [NUM_CH];
	logic signed [SW-1:0]               sum_d;

	// hold the samples alongside the gain stages
	always_ff @(posedge clk) begin
		if (ld.s1) smp_s1 <= sample;
		if (ld.s2) smp_s2 <= smp_s1;
		if (ld.s3) smp_s3 <= smp_s2;
	end

	always_comb begin
		for (int i = 0; i < NUM_CH; i++) begin
			a_ext[i]  = {{(PW-SAMPLE_BITS){smp_s3[i][SAMPLE_BITS-1]}}, smp_s3[i]};
			b_ext[i]  = {{(PW-GAIN_W){1'b0}}, gain_s3[i]};
			prod_d[i] = a_ext[i] * b_ext[i];
		end
	end

	always_ff @(posedge clk) begin
		if (ld.s4) prod_s4 <= prod_d;
	end

	// sum at full width, then floor by 15 bits
	always_comb begin
		sum_d = '0;
		for (int i = 0; i < NUM_CH; i++) begin
			sum_d = sum_d + {{(SW-PW){prod_s4[i][PW-1]}}, prod_s4[i]};
		end
	end

	always_ff @(posedge clk) begin
		if (ld.s5) mix_s5 <= sum_d[GAIN_W-1 +: SAMPLE_BITS+3];
	end

endmodule

### rtl/five_way_scanning_crossfader_unit.sv
// Five-channel scanning crossfader.
// Input beats on up carry a signed Q1.15 scan position (control) and five
// signed samples; each beat yields exactly one beat on down carrying mix, the
// sum of the samples weighted by five overlapping trapezoid gains, floored
// by 15 bits and not saturated.
// Five register stages; mix is taken from the stage 5 register. Throughput is
// one beat per cycle while down is ready: stage 1 selects the gain segment,
// stage 2 divides the ramp numerator by 300 with a reciprocal multiply,
// stage 3 clamps the gains, stage 4 multiplies the samples, stage 5 sums.
// A valid bit travels with each stage. When down stalls, the output beat
// holds and the stages behind it keep filling any empty slots, so up stays
// ready until every stage is occupied; nothing is dropped or repeated.
// Reset clears the valid bits only; the data registers are not reset.
module five_way_scanning_crossfader_unit #(
	parameter int SAMPLE_BITS = fwsx_pkg::SAMPLE_BITS_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	fwsx_in_if.sink           up,
	fwsx_out_if.source        down
);
	import fwsx_pkg::*;

	logic v_s1, v_s2, v_s3, v_s4, v_s5;
	logic rdy1, rdy2, rdy3, rdy4, rdy5;
	stage_ld_t ld;

	logic [NUM_CH-1:0][SAMPLE_BITS-1:0] sample;
	logic [NUM_CH-1:0][GAIN_W-1:0]      gain_s3;
	logic signed [SAMPLE_BITS+2:0]      mix_s5;

	// a stage takes a new beat when empty or when its content moves on
	assign rdy5 = !v_s5 || down.ready;
	assign rdy4 = !v_s4 || rdy5;
	assign rdy3 = !v_s3 || rdy4;
	assign rdy2 = !v_s2 || rdy3;
	assign rdy1 = !v_s1 || rdy2;

	assign ld = '{s1: rdy1, s2: rdy2, s3: rdy3, s4: rdy4, s5: rdy5};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
		end else begin
			if (rdy1) v_s1 <= up.valid;
			if (rdy2) v_s2 <= v_s1;
			if (rdy3) v_s3 <= v_s2;
			if (rdy4) v_s4 <= v_s3;
			if (rdy5) v_s5 <= v_s4;
		end
	end

	assign sample = {up.sample_5, up.sample_4, up.sample_3, up.sample_2, up.sample_1};

	fwsx_gain u_gain (
		.clk     (clk),
		.ld      (ld),
		.control (up.control),
		.gain_s3 (gain_s3)
	);

	fwsx_mac #(
		.SAMPLE_BITS (SAMPLE_BITS)
	) u_mac (
		.clk     (clk),
		.ld      (ld),
		.sample  (sample),
		.gain_s3 (gain_s3),
		.mix_s5  (mix_s5)
	);

	assign up.ready   = rdy1;
	assign down.valid = v_s5;
	assign down.mix   = mix_s5;

endmodule

### dv/fwsx_mix_checker.sv
`timescale 1ns / 100ps

module fwsx_mix_checker (
	input  logic clk,
	input  logic arst_n,
	fwsx_in_if   up,
	fwsx_out_if  down,
	output int   mismatches,
	output int   mixes_pending,
	output int   mixes_checked
);
	import fwsx_pkg::*;

	localparam int SW       = SAMPLE_BITS_DEF;
	localparam int MW       = SW + 3;
	localparam int RAMP_DIV = 300;

	typedef logic [NUM_CH-1:0][SW-1:0] sample_set_t;

	typedef struct {
		logic signed [15:0]   pos;
		logic signed [MW-1:0] mix;
	} mix_expect_t;

	mix_expect_t mix_expect_q[$];
	mix_expect_t head;

	function automatic longint floor_div(longint n, longint d);
		if (n >= 0)
			return n / d;
		return -((-n + d - 1) / d);
	endfunction

	// round n/300 to nearest with ties up, then saturate to 0..1.0
	function automatic longint ramp_to_gain(longint n);
		longint g;
		g = floor_div(n + ROUND, RAMP_DIV);
		if (g < 0)
			g = 0;
		if (g > Q_ONE)
			g = Q_ONE;
		return g;
	endfunction

	function automatic logic signed [MW-1:0] weighted_mix(logic signed [15:0] pos,
		sample_set_t smp);
		longint x;
		longint g [NUM_CH];
		longint acc;
		longint s;
		longint m;
		x = pos;

		g[0] = -2 * x - Q_ONE;
		if (g[0] < 0)
			g[0] = 0;
		if (g[0] > G1_MAX)
			g[0] = G1_MAX;

		if (x < -POS_7_8 || x >= 0)
			g[1] = 0;
		else if (x > -POS_1_2 && x < -POS_3_8)
			g[1] = Q_ONE;
		else if (x >= -POS_3_8)
			g[1] = ramp_to_gain(-SLOPE * x);
		else
			g[1] = ramp_to_gain(SLOPE * (x + POS_7_8));

		if (x < -POS_3_8 || x >= POS_1_2)
			g[2] = 0;
		else if (x > 0 && x < POS_1_8)
			g[2] = Q_ONE;
		else if (x >= POS_1_8)
			g[2] = ramp_to_gain(-SLOPE * x + OFS_133);
		else
			g[2] = ramp_to_gain(SLOPE * (x + POS_3_8));

		if (x < POS_1_8)
			g[3] = 0;
		else if (x > POS_1_2 && x < POS_5_8)
			g[3] = Q_ONE;
		else if (x >= POS_5_8)
			g[3] = ramp_to_gain(-SLOPE * x + OFS_2675);
		else
			g[3] = ramp_to_gain(SLOPE * (x - POS_1_8));

		g[4] = ramp_to_gain(SLOPE * (x - POS_1_2));

		acc = 0;
		for (int i = 0; i < NUM_CH; i++) begin
			s = $signed(smp[i]);
			acc += s * g[i];
		end
		m = floor_div(acc, Q_ONE);
		return m[MW-1:0];
	endfunction

	always @(posedge clk) begin
		if (!arst_n) begin
			mismatches    = 0;
			mixes_checked = 0;
			mixes_pending = 0;
		end else begin
			if (down.valid && down.ready) begin
				if (mix_expect_q.size() == 0) begin
					$display("%0t: mix beat %0d with nothing expected", $time, down.mix);
					mismatches++;
				end else begin
					head = mix_expect_q.pop_front();
					if (down.mix !== head.mix) begin
						$display("%0t: mix mismatch at control %0d: expected %0d, got %0d",
							$time, head.pos, head.mix, down.mix);
						mismatches++;
					end
					mixes_checked++;
				end
			end
			if (up.valid && up.ready) begin
				head.pos = up.control;
				head.mix = weighted_mix(up.control,
					{up.sample_5, up.sample_4, up.sample_3, up.sample_2, up.sample_1});
				mix_expect_q.push_back(head);
			end
			mixes_pending = mix_expect_q.size();
		end
	end

endmodule

### dv/testbench.sv
`timescale 1ns / 100ps

module testbench;
	localparam int SW             = fwsx_pkg::SAMPLE_BITS_DEF;
	localparam int NCH            = fwsx_pkg::NUM_CH;
	localparam int WATCHDOG_LIMIT = 1000;

	typedef logic [NCH-1:0][SW-1:0] sample_set_t;

	logic clk;
	logic arst_n;

	int  mismatches;
	int  mixes_pending;
	int  mixes_checked;
	int  beats_sent;
	int  sink_hold;
	bit  sink_stalls;
	bit  src_idle;

	fwsx_in_if  #(.SAMPLE_BITS(SW)) up_ch ();
	fwsx_out_if #(.SAMPLE_BITS(SW)) down_ch ();

	five_way_scanning_crossfader_unit #(.SAMPLE_BITS(SW)) DUT (
		.clk    (clk),
		.arst_n (arst_n),
		.up     (up_ch),
		.down   (down_ch)
	);

	fwsx_mix_checker u_mix_check (
		.clk           (clk),
		.arst_n        (arst_n),
		.up            (up_ch),
		.down          (down_ch),
		.mismatches    (mismatches),
		.mixes_pending (mixes_pending),
		.mixes_checked (mixes_checked)
	);

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	// mostly no gap, some short, a few long
	function automatic int idle_len();
		int r;
		r = $urandom_range(0, 99);
		if (r < 65)
			return 0;
		if (r < 93)
			return $urandom_range(1, 3);
		if (r < 98)
			return $urandom_range(4, 8);
		return $urandom_range(20, 40);
	endfunction

	// full range, or near a knee of one of the trapezoids, or an end of the scan
	function automatic logic signed [15:0] rand_pos();
		int r;
		int knee;
		r = $urandom_range(0, 9);
		if (r < 5)
			return 16'($urandom());
		if (r == 9)
			return $urandom_range(0, 1) ? 16'h7fff : 16'h8000;
		case ($urandom_range(0, 8))
			0:       knee = -29491;
			1:       knee = -28672;
			2:       knee = -16384;
			3:       knee = -12288;
			4:       knee = 0;
			5:       knee = 4096;
			6:       knee = 16384;
			7:       knee = 20480;
			default: knee = 28672;
		endcase
		return 16'(knee + int'($urandom_range(0, 64)) - 32);
	endfunction

	function automatic sample_set_t rand_samples();
		sample_set_t smp;
		for (int i = 0; i < NCH; i++) begin
			case ($urandom_range(0, 9))
				0:       smp[i] = 16'h7fff;
				1:       smp[i] = 16'h8000;
				2:       smp[i] = $urandom_range(0, 1) ? 16'h0000 : 16'hffff;
				default: smp[i] = 16'($urandom());
			endcase
		end
		return smp;
	endfunction

	// call at a falling edge; returns at the falling edge after the beat is taken
	task automatic send_beat(input logic signed [15:0] pos, input sample_set_t smp);
		int gap;
		gap = src_idle ? idle_len() : 0;
		if (gap > 0) begin
			up_ch.valid = 1'b0;
			repeat (gap) @(negedge clk);
		end
		up_ch.valid    = 1'b1;
		up_ch.control  = pos;
		up_ch.sample_1 = smp[0];
		up_ch.sample_2 = smp[1];
		up_ch.sample_3 = smp[2];
		up_ch.sample_4 = smp[3];
		up_ch.sample_5 = smp[4];
		@(posedge clk);
		while (!up_ch.ready)
			@(posedge clk);
		@(negedge clk);
		beats_sent++;
	endtask

	task automatic send_random(input int count);
		for (int k = 0; k < count; k++)
			send_beat(rand_pos(), rand_samples());
	endtask

	task automatic drain_mixes();
		while (mixes_pending != 0)
			@(negedge clk);
	endtask

	// receiver side: long holds on request, random stalls otherwise
	initial begin
		int stall;
		stall         = 0;
		down_ch.ready = 1'b0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (sink_hold > 0) begin
				down_ch.ready = 1'b0;
				sink_hold--;
			end else if (stall > 0) begin
				down_ch.ready = 1'b0;
				stall--;
			end else if (sink_stalls && $urandom_range(0, 99) < 30) begin
				down_ch.ready = 1'b0;
				stall = idle_len();
			end else begin
				down_ch.ready = 1'b1;
			end
		end
	end

	initial begin
		int idle;
		idle = 0;
		@(posedge arst_n);
		while (idle < WATCHDOG_LIMIT) begin
			@(posedge clk);
			if ((up_ch.valid && up_ch.ready) || (down_ch.valid && down_ch.ready))
				idle = 0;
			else
				idle++;
		end
		$display("%0t: timeout, no beat moved for %0d cycles", $time, idle);
		$display("CHECKS FAILED");
		$finish;
	end

	initial begin
		logic signed [15:0] corner_pos [20];
		sample_set_t smp;

		arst_n         = 1'b0;
		up_ch.valid    = 1'b0;
		up_ch.control  = '0;
		up_ch.sample_1 = '0;
		up_ch.sample_2 = '0;
		up_ch.sample_3 = '0;
		up_ch.sample_4 = '0;
		up_ch.sample_5 = '0;
		beats_sent     = 0;
		sink_hold      = 0;
		sink_stalls    = 1'b0;
		src_idle       = 1'b0;

		repeat (9) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// scan ends, dead-zone and flat-top edges, channel three's dip below zero
		// near one half, channel four's peak above one near five eighths
		corner_pos = '{16'sh8000, -16'sd29491, -16'sd28673, -16'sd28672, -16'sd16384,
			-16'sd16383, -16'sd12289, -16'sd12288, -16'sd1, 16'sd0, 16'sd1, 16'sd4095,
			16'sd4096, 16'sd16383, 16'sd16384, 16'sd20479, 16'sd20480, 16'sd20481,
			16'sd28672, 16'sh7fff};
		for (int k = 0; k < 20; k++) begin
			for (int i = 0; i < NCH; i++) begin
				case (k % 4)
					0:       smp[i] = 16'h7fff;
					1:       smp[i] = 16'h8000;
					2:       smp[i] = (i % 2) ? 16'h8000 : 16'h7fff;
					default: smp[i] = 16'($urandom());
				endcase
			end
			send_beat(corner_pos[k], smp);
		end

		sink_stalls = 1'b1;
		src_idle    = 1'b1;
		send_random(400);

		// hold the output off while beats keep coming, so up has to stall
		sink_hold = 80;
		src_idle  = 1'b0;
		send_random(100);

		up_ch.valid = 1'b0;
		drain_mixes();

		sink_stalls = 1'b0;
		send_random(400);

		sink_stalls = 1'b1;
		src_idle    = 1'b1;
		send_random(600);
		up_ch.valid = 1'b0;

		drain_mixes();
		repeat (20) @(posedge clk);

		$display("Sent %0d beats: scan corners, random and near-knee positions,", beats_sent);
		$display("random gaps, a long output hold and a back-to-back burst; %0d mixes checked",
			mixes_checked);
		if (mismatches == 0 && mixes_pending == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end

endmodule
